// File: hdl/pst_pkg.sv
// Shared types and codes of the persistent segment tree block.
`timescale 1ns / 1ps
`default_nettype none
package pst_pkg;

    // Operation codes carried in the func field
    localparam logic [1:0] FN_MODIFY = 2'd0;
    localparam logic [1:0] FN_KTH    = 2'd1;
    localparam logic [1:0] FN_RANGE  = 2'd2;
    localparam logic [1:0] FN_NOP    = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_NO_VER = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] base_version;
        logic [11:0] top_version;
        logic [15:0] position;
        logic [31:0] delta;
        logic [31:0] rank;
        logic [15:0] range_low;
        logic [15:0] range_high;
    } in_t;

    typedef struct packed {
        logic [11:0] new_version;
        logic [47:0] answer;
        logic [1:0]  status;
    } out_t;

    // Datapath commands issued by the controller, one per cycle
    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_CHECK,
        CMD_MOD_READ,
        CMD_MOD_WRITE,
        CMD_WALK_NODE,
        CMD_WALK_LEFT,
        CMD_WALK_STEP,
        CMD_LEAF_READ,
        CMD_LEAF_ADD,
        CMD_RESTART,
        CMD_FINISH
    } cmd_t;

    // Datapath status seen by the controller
    typedef struct packed {
        logic go_modify;
        logic go_walk;
        logic mod_last;
        logic walk_last;
        logic is_range;
        logic need_second;
    } dp_stat_t;

endpackage
`default_nettype wire

// File: hdl/pst_datapath.sv
// Datapath of the persistent segment tree: version roots, node pool and walk registers.
`timescale 1ns / 1ps
`default_nettype none
module pst_datapath
    import pst_pkg::*;
#(
    parameter int POSITION_BITS = 16,
    parameter int VERSION_COUNT = 4096,
    parameter int NODE_COUNT    = 131072
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire in_t      s_data,
    input  wire cmd_t     cmd,
    output dp_stat_t      stat,
    output out_t          m_data
);
    localparam int PB    = POSITION_BITS;
    localparam int VB    = (VERSION_COUNT > 1) ? $clog2(VERSION_COUNT) : 1;
    localparam int NB    = $clog2(NODE_COUNT);
    localparam int LW    = $clog2(PB + 1) + 1;
    localparam int XW    = PB + 16;
    localparam int REC_W = 2 * NB + 48;

    // Latched request
    in_t               req_reg;
    // Allocation counters
    logic [VB:0]       vu_reg, vu_next;
    logic [NB:0]       nu_reg, nu_next;
    // Result fields
    logic [1:0]        status_reg;
    logic [11:0]       newv_reg;
    out_t              out_reg;
    // Walk registers
    logic [NB-1:0]     root_p_reg, root_q_reg;
    logic [NB-1:0]     p_reg, q_reg, lp_reg, lq_reg, rp_reg, rq_reg;
    logic [NB-1:0]     oldn_reg, nw_reg;
    logic [LW-1:0]     lvl_reg;
    logic [PB-1:0]     path_reg, kpos_reg;
    logic signed [53:0] k_reg;
    logic [47:0]       acc_reg;
    logic              phase_reg;

    // Memories
    logic [NB-1:0]     root_mem [VERSION_COUNT];
    logic [NB-1:0]     root_a_q, root_b_q;
    logic              root_a_zero, root_b_zero;
    logic [REC_W-1:0]  node_mem [NODE_COUNT];
    logic [REC_W-1:0]  node_a_q, node_b_q;
    logic              node_a_zero, node_b_zero;

    logic [VB-1:0]     root_ra, root_rb;
    logic              root_we;
    logic [NB-1:0]     node_ra, node_rb;
    logic              node_we;
    logic [REC_W-1:0]  node_wdata;

    // Request-derived values
    logic [31:0]       base_w, top_w, vu_w, nu_free;
    logic              bad_ver, full, empty;
    logic [XW-1:0]     hi_x, lo_x, pmax_x, hi_c, lo_m1_x, pos_x;
    logic [47:0]       delta48;
    logic [NB-1:0]     root_a, root_b;
    logic [NB-1:0]     a_left, a_right, b_left, b_right;
    logic [47:0]       a_sum, b_sum, diff;
    logic signed [53:0] diff54;
    logic [NB-1:0]     child;

    // Root read addresses come straight from the incoming beat
    assign root_ra = VB'(32'(s_data.base_version));
    assign root_rb = VB'(32'(s_data.top_version));
    assign root_we = (cmd == CMD_CHECK) && stat.go_modify;

    always_ff @(posedge aclk) begin
        if (root_we) begin
            root_mem[vu_reg[VB-1:0]] <= nu_reg[NB-1:0];
        end
        root_a_q    <= root_mem[root_ra];
        root_b_q    <= root_mem[root_rb];
        root_a_zero <= (root_ra == '0);
        root_b_zero <= (root_rb == '0);
    end

    // Entry zero is the empty node and is never written
    assign root_a = root_a_zero ? '0 : root_a_q;
    assign root_b = root_b_zero ? '0 : root_b_q;

    // Node read addresses follow the command
    always_comb begin
        node_ra = p_reg;
        node_rb = q_reg;
        unique case (cmd)
            CMD_MOD_READ:  node_ra = oldn_reg;
            CMD_WALK_LEFT: begin
                node_ra = a_left;
                node_rb = b_left;
            end
            CMD_RESTART: begin
                node_ra = root_p_reg;
                node_rb = root_q_reg;
            end
            default: begin
                node_ra = p_reg;
                node_rb = q_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[nw_reg] <= node_wdata;
        end
        node_a_q    <= node_mem[node_ra];
        node_b_q    <= node_mem[node_rb];
        node_a_zero <= (node_ra == '0);
        node_b_zero <= (node_rb == '0);
    end

    // Node zero reads as links to itself and zero sum
    always_comb begin
        {a_left, a_right, a_sum} = node_a_zero ? '0 : node_a_q;
        {b_left, b_right, b_sum} = node_b_zero ? '0 : node_b_q;
    end

    assign diff   = b_sum - a_sum;
    assign diff54 = $signed({{6{diff[47]}}, diff});

    // Request checks
    always_comb begin
        base_w  = 32'(req_reg.base_version);
        top_w   = 32'(req_reg.top_version);
        vu_w    = 32'(vu_reg);
        nu_free = 32'(NODE_COUNT) - 32'(nu_reg);
        bad_ver = (base_w >= vu_w) ||
                  ((req_reg.func != FN_MODIFY) && (top_w >= vu_w));
        full    = (vu_w >= 32'(VERSION_COUNT)) || (nu_free < 32'(PB + 1));
        hi_x    = XW'(req_reg.range_high);
        lo_x    = XW'(req_reg.range_low);
        pos_x   = XW'(req_reg.position);
        pmax_x  = (XW'(1) << PB) - XW'(1);
        hi_c    = (hi_x > pmax_x) ? pmax_x : hi_x;
        empty   = lo_x > hi_c;
        lo_m1_x = lo_x - XW'(1);
        delta48 = {{16{req_reg.delta[31]}}, req_reg.delta};
    end

    always_comb begin
        stat.go_modify   = (req_reg.func == FN_MODIFY) && !bad_ver && !full;
        stat.go_walk     = !bad_ver && ((req_reg.func == FN_KTH) ||
                           ((req_reg.func == FN_RANGE) && !empty));
        stat.mod_last    = (lvl_reg == LW'(PB));
        stat.walk_last   = (lvl_reg == LW'(PB - 1));
        stat.is_range    = (req_reg.func == FN_RANGE);
        stat.need_second = !phase_reg && (lo_x != '0);
    end

    // New path node: copy the old node, add delta, relink the walked side
    always_comb begin
        child      = nw_reg + NB'(1);
        node_we    = (cmd == CMD_MOD_WRITE);
        node_wdata = {a_left, a_right, a_sum + delta48};
        if (!stat.mod_last) begin
            if (path_reg[PB-1]) begin
                node_wdata = {a_left, child, a_sum + delta48};
            end else begin
                node_wdata = {child, a_right, a_sum + delta48};
            end
        end
    end

    // Allocation counters
    always_comb begin
        vu_next = vu_reg;
        nu_next = nu_reg;
        if (root_we) begin
            vu_next = vu_reg + (VB + 1)'(1);
            nu_next = nu_reg + (NB + 1)'(PB + 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vu_reg <= (VB + 1)'(1);
            nu_reg <= (NB + 1)'(1);
        end else begin
            vu_reg <= vu_next;
            nu_reg <= nu_next;
        end
    end

    // Walk and result registers
    always_ff @(posedge aclk) begin
        unique case (cmd)
            CMD_LOAD: begin
                req_reg <= s_data;
            end
            CMD_CHECK: begin
                newv_reg   <= '0;
                acc_reg    <= '0;
                kpos_reg   <= '0;
                phase_reg  <= 1'b0;
                lvl_reg    <= '0;
                k_reg      <= $signed({22'd0, req_reg.rank});
                root_p_reg <= root_a;
                root_q_reg <= root_b;
                p_reg      <= root_a;
                q_reg      <= root_b;
                oldn_reg   <= root_a;
                nw_reg     <= nu_reg[NB-1:0];
                if (req_reg.func == FN_MODIFY) begin
                    path_reg <= pos_x[PB-1:0];
                end else begin
                    path_reg <= hi_c[PB-1:0];
                end
                if (root_we) begin
                    newv_reg <= 12'(vu_reg);
                end
                if (req_reg.func == FN_NOP) begin
                    status_reg <= ST_OK;
                end else if (bad_ver) begin
                    status_reg <= ST_NO_VER;
                end else if ((req_reg.func == FN_MODIFY) && full) begin
                    status_reg <= ST_FULL;
                end else begin
                    status_reg <= ST_OK;
                end
            end
            CMD_MOD_WRITE: begin
                oldn_reg <= path_reg[PB-1] ? a_right : a_left;
                nw_reg   <= child;
                lvl_reg  <= lvl_reg + LW'(1);
                path_reg <= path_reg << 1;
            end
            CMD_WALK_LEFT: begin
                lp_reg <= a_left;
                lq_reg <= b_left;
                rp_reg <= a_right;
                rq_reg <= b_right;
            end
            CMD_WALK_STEP: begin
                lvl_reg  <= lvl_reg + LW'(1);
                path_reg <= path_reg << 1;
                if (stat.is_range) begin
                    if (path_reg[PB-1]) begin
                        acc_reg <= phase_reg ? acc_reg - diff : acc_reg + diff;
                        p_reg   <= rp_reg;
                        q_reg   <= rq_reg;
                    end else begin
                        p_reg <= lp_reg;
                        q_reg <= lq_reg;
                    end
                end else if (k_reg <= diff54) begin
                    p_reg    <= lp_reg;
                    q_reg    <= lq_reg;
                    kpos_reg <= kpos_reg << 1;
                end else begin
                    k_reg    <= k_reg - diff54;
                    p_reg    <= rp_reg;
                    q_reg    <= rq_reg;
                    kpos_reg <= (kpos_reg << 1) | PB'(1);
                end
            end
            CMD_LEAF_ADD: begin
                acc_reg <= phase_reg ? acc_reg - diff : acc_reg + diff;
            end
            CMD_RESTART: begin
                p_reg     <= root_p_reg;
                q_reg     <= root_q_reg;
                path_reg  <= lo_m1_x[PB-1:0];
                lvl_reg   <= '0;
                phase_reg <= 1'b1;
            end
            CMD_FINISH: begin
                out_reg.new_version <= newv_reg;
                out_reg.status      <= status_reg;
                if (status_reg != ST_OK) begin
                    out_reg.answer <= '0;
                end else if (req_reg.func == FN_KTH) begin
                    out_reg.answer <= 48'(kpos_reg);
                end else if (req_reg.func == FN_RANGE) begin
                    out_reg.answer <= acc_reg;
                end else begin
                    out_reg.answer <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_data = out_reg;

endmodule
`default_nettype wire

// File: hdl/pst_ctrl.sv
// Controller of the persistent segment tree: sequences one operation and owns the handshakes.
`timescale 1ns / 1ps
`default_nettype none
module pst_ctrl
    import pst_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    input  wire dp_stat_t stat,
    output cmd_t          cmd
);
    typedef enum logic [9:0] {
        S_IDLE      = 10'b0000000001,
        S_CHECK     = 10'b0000000010,
        S_MOD_READ  = 10'b0000000100,
        S_MOD_WRITE = 10'b0000001000,
        S_WALK_NODE = 10'b0000010000,
        S_WALK_LEFT = 10'b0000100000,
        S_WALK_STEP = 10'b0001000000,
        S_LEAF_READ = 10'b0010000000,
        S_LEAF_ADD  = 10'b0100000000,
        S_FINISH    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   slot_free;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign slot_free = !m_valid_reg || m_ready;

    // Next state and command
    always_comb begin
        state_next   = state_reg;
        cmd          = CMD_NOP;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd        = CMD_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd = CMD_CHECK;
                if (stat.go_modify) begin
                    state_next = S_MOD_READ;
                end else if (stat.go_walk) begin
                    state_next = S_WALK_NODE;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_MOD_READ: begin
                cmd        = CMD_MOD_READ;
                state_next = S_MOD_WRITE;
            end
            S_MOD_WRITE: begin
                cmd        = CMD_MOD_WRITE;
                state_next = stat.mod_last ? S_FINISH : S_MOD_READ;
            end
            S_WALK_NODE: begin
                cmd        = CMD_WALK_NODE;
                state_next = S_WALK_LEFT;
            end
            S_WALK_LEFT: begin
                cmd        = CMD_WALK_LEFT;
                state_next = S_WALK_STEP;
            end
            S_WALK_STEP: begin
                cmd = CMD_WALK_STEP;
                if (!stat.walk_last) begin
                    state_next = S_WALK_NODE;
                end else if (stat.is_range) begin
                    state_next = S_LEAF_READ;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_LEAF_READ: begin
                cmd        = CMD_LEAF_READ;
                state_next = S_LEAF_ADD;
            end
            S_LEAF_ADD: begin
                cmd = CMD_LEAF_ADD;
                if (stat.need_second) begin
                    state_next = S_WALK_NODE;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (slot_free) begin
                    cmd          = CMD_FINISH;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/pst_restart.sv
// Second-prefix launcher of the range sum: rewinds the walk for the lower bound.
`timescale 1ns / 1ps
`default_nettype none
module pst_restart
    import pst_pkg::*;
(
    input  wire cmd_t     ctrl_cmd,
    input  wire dp_stat_t stat,
    input  wire logic     leaf_done,
    output cmd_t          dp_cmd
);
    // Turn the walk-node beat after a leaf add that needs a second prefix into a rewind beat
    always_comb begin
        dp_cmd = ctrl_cmd;
        if (leaf_done && stat.need_second && (ctrl_cmd == CMD_WALK_NODE)) begin
            dp_cmd = CMD_RESTART;
        end
    end

endmodule
`default_nettype wire

// File: hdl/persistent_segment_tree_top.sv
// Top level of the persistent segment tree block.
//
// Usage: one request beat on s_valid/s_ready/s_data (func, versions, position,
// delta, rank, range bounds) gives exactly one result beat on
// m_valid/m_ready/m_data (new_version, answer, status).
// Operations run one at a time; a new request is taken as soon as the
// controller is back in idle, even while the previous result still waits in
// the output register.
// The run time of an operation is set by the dependent node-memory reads
// of the tree walk; refused or unknown requests skip the walk and finish.
// Reset (synchronous, active low) returns to version 0 with one node used;
// no memory clearing pass is needed, node 0 and root 0 are decoded.
// When the receiver stalls the finished result holds in the output register
// and the next finished operation waits for the slot.
`timescale 1ns / 1ps
`default_nettype none
module persistent_segment_tree_top
    import pst_pkg::*;
#(
    parameter int POSITION_BITS = 16,
    parameter int VERSION_COUNT = 4096,
    parameter int NODE_COUNT    = 131072
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);
    cmd_t     ctrl_cmd, dp_cmd;
    dp_stat_t stat;
    logic     leaf_done_reg;

    // Remember that the last beat was a leaf add
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leaf_done_reg <= 1'b0;
        end else begin
            leaf_done_reg <= (ctrl_cmd == CMD_LEAF_ADD);
        end
    end

    pst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (ctrl_cmd)
    );

    pst_restart u_restart (
        .ctrl_cmd  (ctrl_cmd),
        .stat      (stat),
        .leaf_done (leaf_done_reg),
        .dp_cmd    (dp_cmd)
    );

    pst_datapath #(
        .POSITION_BITS (POSITION_BITS),
        .VERSION_COUNT (VERSION_COUNT),
        .NODE_COUNT    (NODE_COUNT)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (dp_cmd),
        .stat    (stat),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

// File: hdl/pst_checker.sv
// Port checker of the persistent segment tree and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pst_checker
    import pst_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire in_t  s_data,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire out_t m_data
);
    // Result beat holds until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed while stalled");

    // No result right after reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // One operation at a time: no request taken in the cycle after one is taken
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    // Refused results carry no version and no answer
    a_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ST_OK) |->
            (m_data.new_version == '0) && (m_data.answer == '0))
        else $error("refused result with payload");

    // Status never takes the unused code
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == ST_OK) || (m_data.status == ST_FULL) ||
                    (m_data.status == ST_NO_VER))
        else $error("unknown status code");

endmodule

bind persistent_segment_tree_top pst_checker u_pst_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

// File: sim/pst_checker.sv
// Result checker for the persistent segment tree: predicts each request and compares results.
`timescale 1ns / 1ps
module pst_scoreboard
    import pst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_t         s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_t        m_data,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);
    localparam int PBITS  = 16;
    localparam int NVER   = 4096;
    localparam int NNODES = 131072;

    logic [16:0] root_of [NVER];
    logic [16:0] lft [NNODES];
    logic [16:0] rgt [NNODES];
    logic [47:0] tot [NNODES];
    int unsigned node_top;
    int unsigned ver_top;
    out_t result_queue [$];

    function automatic logic [47:0] lsum(logic [16:0] n);
        return (n == 0) ? 48'd0 : tot[n];
    endfunction
    function automatic logic [16:0] lleft(logic [16:0] n);
        return (n == 0) ? 17'd0 : lft[n];
    endfunction
    function automatic logic [16:0] lright(logic [16:0] n);
        return (n == 0) ? 17'd0 : rgt[n];
    endfunction

    // Sum of positions 0..hi of (q - p)
    function automatic logic [47:0] prefix_sum(logic [16:0] p, logic [16:0] q,
                                               logic [15:0] hi);
        logic [47:0] acc;
        acc = '0;
        for (int d = 0; d < PBITS; d++) begin
            if (hi[PBITS-1-d]) begin
                acc += lsum(lleft(q)) - lsum(lleft(p));
                p = lright(p);
                q = lright(q);
            end else begin
                p = lleft(p);
                q = lleft(q);
            end
        end
        acc += lsum(q) - lsum(p);
        return acc;
    endfunction

    // Apply one request to the tree copy and return its result
    function automatic out_t tree_apply(in_t r);
        out_t o;
        logic [47:0] dl;
        logic [16:0] oldn, nw, child, p, q;
        logic signed [63:0] k, x;
        logic [15:0] pos;
        o = '0;
        if (r.func == FN_MODIFY) begin
            dl = {{16{r.delta[31]}}, r.delta};
            if (r.base_version >= ver_top) o.status = ST_NO_VER;
            else if (ver_top >= NVER || NNODES - node_top < PBITS + 1) o.status = ST_FULL;
            else begin
                oldn = root_of[r.base_version];
                nw = node_top[16:0];
                node_top++;
                root_of[ver_top] = nw;
                o.new_version = ver_top[11:0];
                ver_top++;
                for (int d = 0; d <= PBITS; d++) begin
                    lft[nw] = lleft(oldn);
                    rgt[nw] = lright(oldn);
                    tot[nw] = lsum(oldn) + dl;
                    if (d == PBITS) break;
                    child = node_top[16:0];
                    node_top++;
                    if (r.position[PBITS-1-d]) begin
                        rgt[nw] = child;
                        oldn = lright(oldn);
                    end else begin
                        lft[nw] = child;
                        oldn = lleft(oldn);
                    end
                    nw = child;
                end
            end
        end else if (r.func == FN_KTH || r.func == FN_RANGE) begin
            if (r.base_version >= ver_top || r.top_version >= ver_top)
                o.status = ST_NO_VER;
            else begin
                p = root_of[r.base_version];
                q = root_of[r.top_version];
                if (r.func == FN_KTH) begin
                    k = {32'd0, r.rank};
                    pos = '0;
                    for (int d = 0; d < PBITS; d++) begin
                        x = signed'(48'(lsum(lleft(q)) - lsum(lleft(p))));
                        if (k <= x) begin
                            p = lleft(p);
                            q = lleft(q);
                            pos = {pos[14:0], 1'b0};
                        end else begin
                            k -= x;
                            p = lright(p);
                            q = lright(q);
                            pos = {pos[14:0], 1'b1};
                        end
                    end
                    o.answer = {32'd0, pos};
                end else if (r.range_low <= r.range_high) begin
                    o.answer = prefix_sum(p, q, r.range_high);
                    if (r.range_low > 0)
                        o.answer -= prefix_sum(p, q, r.range_low - 16'd1);
                end
            end
        end
        return o;
    endfunction

    assign pending_count = result_queue.size();

    // Predict on each request beat, compare on each result beat
    always @(posedge aclk) begin
        out_t exp_res;
        if (!aresetn) begin
            node_top   = 1;
            ver_top    = 1;
            root_of[0] = '0;
            result_queue.delete();
            fail_count <= 0;
            result_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                result_count <= result_count + 1;
                if (result_queue.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result beat %h", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_res = result_queue.pop_front();
                    if (exp_res !== m_data) begin
                        if (fail_count < 10)
                            $display("mismatch: exp ver=%0d ans=%h st=%0d, got ver=%0d ans=%h st=%0d",
                                     exp_res.new_version, exp_res.answer, exp_res.status,
                                     m_data.new_version, m_data.answer, m_data.status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready)
                result_queue.push_back(tree_apply(s_data));
        end
    end
endmodule

// File: sim/tb.sv
// Testbench top: drives requests into the persistent segment tree and gives the verdict.
`timescale 1ns / 1ps
module tb;
    import pst_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    int   fail_count, pending_count, result_count;
    int   cycle_count = 0;
    int   ver_made = 1;
    int   burst_left = 0;

    always #10 aclk = ~aclk;

    persistent_segment_tree_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    pst_scoreboard chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    // Receiver stalls: runs of ready and stall, sometimes long stall-free stretches
    always @(posedge aclk) begin
        if (cycle_count % 2000 < 400) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    // Timeout guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("timeout");
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Pick a version mostly among the existing ones
    function automatic logic [11:0] pick_ver();
        if ($urandom_range(0, 19) == 0) return 12'($urandom);
        return 12'($urandom_range(0, ver_made - 1));
    endfunction

    function automatic in_t random_req();
        in_t r;
        r = '0;
        r.func = ($urandom_range(0, 29) == 0) ? FN_NOP : 2'($urandom_range(0, 2));
        r.base_version = pick_ver();
        r.top_version = pick_ver();
        r.position = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 15)) : 16'($urandom);
        case ($urandom_range(0, 3))
            0: r.delta = $urandom;
            default: r.delta = 32'($urandom_range(0, 20)) - 32'd5;
        endcase
        r.rank = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 60));
        r.range_low = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 20)) : 16'($urandom);
        r.range_high = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 40)) : 16'($urandom);
        return r;
    endfunction

    // Send one request beat, with random gaps between bursts
    task automatic send(in_t r);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (r.func == FN_MODIFY && r.base_version < ver_made && ver_made < 4096) ver_made++;
        if (burst_left == 0) s_valid <= 1'b0;
    endtask

    task automatic mk(logic [1:0] f, int b, int t, int p, logic [31:0] d, logic [31:0] k,
                      int lo, int hi);
        in_t r;
        r.func = f; r.base_version = 12'(b); r.top_version = 12'(t);
        r.position = 16'(p); r.delta = d; r.rank = k;
        r.range_low = 16'(lo); r.range_high = 16'(hi);
        send(r);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Directed: extremes, each operation, unknown versions, empty range, odd ranks
        mk(FN_KTH, 0, 0, 0, 0, 1, 0, 0);
        mk(FN_RANGE, 0, 0, 0, 0, 0, 0, 16'hFFFF);
        mk(FN_MODIFY, 1, 0, 5, 7, 0, 0, 0);
        mk(FN_KTH, 0, 4095, 0, 0, 1, 0, 0);
        mk(FN_MODIFY, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0);
        mk(FN_MODIFY, 1, 0, 16'hFFFF, 32'h8000_0000, 0, 0, 0);
        mk(FN_MODIFY, 2, 0, 16'h8000, 32'hFFFF_FFFF, 0, 0, 0);
        mk(FN_MODIFY, 3, 4095, 16'h00FF, 3, 0, 0, 0);
        mk(FN_KTH, 0, 4, 0, 0, 0, 0, 0);
        mk(FN_KTH, 0, 4, 0, 0, 1, 0, 0);
        mk(FN_KTH, 0, 4, 0, 0, 32'hFFFF_FFFF, 0, 0);
        mk(FN_KTH, 4, 0, 0, 0, 2, 0, 0);
        mk(FN_RANGE, 0, 4, 0, 0, 0, 0, 16'hFFFF);
        mk(FN_RANGE, 0, 4, 0, 0, 0, 16'hFFFF, 16'hFFFF);
        mk(FN_RANGE, 0, 4, 0, 0, 0, 10, 3);
        mk(FN_RANGE, 4, 1, 0, 0, 0, 1, 16'hFF00);
        mk(FN_RANGE, 0, 4095, 0, 0, 0, 0, 10);
        mk(FN_NOP, 1, 2, 3, 4, 5, 6, 7);
        // Random traffic
        for (int i = 0; i < 400; i++) send(random_req());
        if (burst_left != 0) s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        $display("covered %0d results over %0d versions: modify, k-th and range sums",
                 result_count, ver_made);
        if (fail_count == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end
endmodule
